/* src/bpf_pkg.sv */
package bpf_pkg;

  localparam int NUM_REGS = 8;
  localparam int PT_NUM = 6;

  localparam logic [2:0] REG_POINT0 = 3'd0;
  localparam logic [2:0] REG_POINT5 = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;
  localparam logic [2:0] REG_SPEED = 3'd7;

  typedef logic [31:0] point_t;
  typedef point_t [PT_NUM-1:0] point_arr_t;

  localparam point_arr_t PT_RESET = {
    32'd9830700, 32'd3276900, 32'd9830500, 32'd13107400, 32'd6553800, 32'd0
  };
  localparam logic [15:0] LIMIT_RESET = 16'd600;
  localparam logic [9:0] SPEED_RESET = 10'd200;

  // step counts of the serial units
  localparam logic [4:0] MUL_STEPS = 5'd19;
  localparam logic [4:0] MOD_STEPS = 5'd17;
  localparam logic [4:0] DIV_STEPS = 5'd18;
  localparam logic [4:0] DIV3_STEPS = 5'd21;

  localparam logic [20:0] W_ONE = 21'd65536;
  localparam logic [20:0] W_FOUR = 21'd262144;

endpackage

/* src/bspline_path_follower.sv */
// Bit-serial path follower on a uniform cubic B-spline. Each tick word
// advances the lap distance by elapsed_time * travel_speed, wraps it modulo
// the lap limit, and gives the curve position (1/16 units), the 15-degree
// heading frame and the segment in use. One shift-add multiplier and
// restoring dividers retire one bit per cycle; a tick runs the advance, the wrap,
// the segment division, the powers of u, the weighted sums and the final scaling
// in that order, with the advance, the powers and the sums all on that shared
// multiplier. A new tick is taken while the previous result still waits on the
// output.
module bspline_path_follower (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        elapsed_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] pos_x,
  output logic signed [19:0] pos_y,
  output logic [8:0]         heading_deg,
  output logic [1:0]         segment_index
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INC  = 4'd1;
  localparam logic [3:0] ST_MOD  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_PWR  = 4'd4;
  localparam logic [3:0] ST_LOAD = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_DIV3 = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  bpf_pkg::point_arr_t pts;
  logic [15:0] lim;
  logic [9:0]  spd;
  logic [31:0] travelled;

  logic [3:0]  state;
  logic [4:0]  cnt;
  logic [2:0]  idx;

  logic signed [39:0] ma, acc;
  logic [18:0] mb;

  logic [16:0] dh;
  logic [15:0] dl, rm;
  logic [31:0] rem;
  logic [17:0] dsh, q;
  logic [15:0] u2, u3;
  logic [16:0] m2, m3;
  logic [20:0] sh3, q3;
  logic [1:0]  r3;
  logic        neg;
  logic signed [19:0] px, py;

  logic [15:0] lim_eff;
  assign lim_eff = (lim == 16'd0) ? 16'd1 : lim;

  // multiplier step
  logic signed [39:0] acc_n;
  assign acc_n = mb[0] ? acc + ma : acc;

  // wrap step
  logic [16:0] mt;
  logic        mge;
  logic [15:0] rm_n;
  assign mt = {rm, dh[16]};
  assign mge = mt >= {1'b0, lim_eff};
  assign rm_n = mge ? 16'(mt - {1'b0, lim_eff}) : mt[15:0];

  // segment division step
  logic [32:0] dt, big_l;
  logic        dge;
  logic [17:0] q_n;
  assign big_l = {1'b0, lim_eff, 16'd0};
  assign dt = {rem, dsh[17]};
  assign dge = dt >= big_l;
  assign q_n = {q[16:0], dge};

  // divide by three step
  logic [2:0]  t3;
  logic        ge3;
  logic [20:0] q3_n;
  logic [19:0] mag3;
  logic signed [19:0] val3;
  assign t3 = {r3, sh3[20]};
  assign ge3 = t3 >= 3'd3;
  assign q3_n = {q3[19:0], ge3};
  assign mag3 = q3_n[19:0];
  assign val3 = neg ? -$signed(mag3) : $signed(mag3);

  logic [15:0] u;
  logic [16:0] m17;
  assign u = q[15:0];
  assign m17 = 17'h10000 - {1'b0, u};

  logic [39:0] mag_s;
  assign mag_s = acc_n[39] ? 40'(-acc_n) : 40'(acc_n);

  // basis weights, scaled by six
  logic [20:0] w1f, w2f;
  assign w1f = bpf_pkg::W_FOUR + 21'({u3, 1'b0}) + 21'(u3) - 21'({u2, 2'b0})
               - 21'({u2, 1'b0});
  assign w2f = bpf_pkg::W_ONE - 21'({u3, 1'b0}) - 21'(u3) + 21'({u2, 1'b0}) + 21'(u2)
               + 21'({u, 1'b0}) + 21'(u);

  logic [2:0]  pidx;
  logic [31:0] pt;
  logic [15:0] coord;
  logic [18:0] wsel;
  assign pidx = 3'(q[17:16]) + {1'b0, idx[1:0]};
  assign pt = pts[pidx];
  assign coord = idx[2] ? pt[31:16] : pt[15:0];
  always_comb begin
    case (idx[1:0])
      2'd0: wsel = 19'(m3);
      2'd1: wsel = w1f[18:0];
      2'd2: wsel = w2f[18:0];
      default: wsel = 19'(u3);
    endcase
  end

  logic [32:0] dsum;
  assign dsum = {1'b0, travelled} + {7'd0, acc_n[25:0]};
  logic [31:0] dnew;
  logic [33:0] p34;
  assign dnew = {rm_n, dl};
  assign p34 = {2'b0, dnew} + {1'b0, dnew, 1'b0};

  logic [4:0] hq;
  assign hq = q[17:13];

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pts <= bpf_pkg::PT_RESET;
      lim <= bpf_pkg::LIMIT_RESET;
      spd <= bpf_pkg::SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpf_pkg::REG_LIMIT: lim <= cfg_data[15:0];
        bpf_pkg::REG_SPEED: spd <= cfg_data[9:0];
        default: pts[cfg_index] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      travelled <= 32'd0;
      out_valid <= 1'b0;
      cnt <= 5'd0;
      idx <= 3'd0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      unique case (state) inside
        ST_IDLE: begin
          if (in_valid) begin
            ma <= 40'(elapsed_time);
            mb <= 19'(spd);
            acc <= '0;
            cnt <= 5'd0;
            state <= ST_INC;
          end
        end
        ST_INC, ST_PWR, ST_SUM: begin
          acc <= acc_n;
          ma <= ma <<< 1;
          mb <= mb >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == bpf_pkg::MUL_STEPS - 5'd1) begin
            cnt <= 5'd0;
            if (state == ST_INC) begin
              dh <= dsum[32:16];
              dl <= dsum[15:0];
              rm <= 16'd0;
              state <= ST_MOD;
            end else if (state == ST_PWR) begin
              acc <= '0;
              idx <= idx + 3'd1;
              case (idx[1:0])
                2'd0: begin
                  u2 <= acc_n[31:16];
                  ma <= 40'(acc_n[31:16]);
                  mb <= 19'(u);
                end
                2'd1: begin
                  u3 <= acc_n[31:16];
                  ma <= 40'(m17);
                  mb <= 19'(m17);
                end
                2'd2: begin
                  m2 <= acc_n[32:16];
                  ma <= 40'(acc_n[32:16]);
                  mb <= 19'(m17);
                end
                default: begin
                  m3 <= acc_n[32:16];
                  idx <= 3'd0;
                  state <= ST_LOAD;
                end
              endcase
            end else begin
              if (idx[1:0] == 2'd3) begin
                neg <= acc_n[39];
                sh3 <= mag_s[33:13];
                r3 <= 2'd0;
                q3 <= '0;
                state <= ST_DIV3;
              end else begin
                idx <= idx + 3'd1;
                state <= ST_LOAD;
              end
            end
          end
        end
        ST_MOD: begin
          rm <= rm_n;
          dh <= dh << 1;
          cnt <= cnt + 5'd1;
          if (cnt == bpf_pkg::MOD_STEPS - 5'd1) begin
            cnt <= 5'd0;
            travelled <= dnew;
            rem <= p34[33:2];
            dsh <= {p34[1:0], 16'd0};
            q <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= dge ? 32'(dt - big_l) : dt[31:0];
          dsh <= dsh << 1;
          q <= q_n;
          cnt <= cnt + 5'd1;
          if (cnt == bpf_pkg::DIV_STEPS - 5'd1) begin
            cnt <= 5'd0;
            ma <= 40'(q_n[15:0]);
            mb <= 19'(q_n[15:0]);
            acc <= '0;
            idx <= 3'd0;
            state <= ST_PWR;
          end
        end
        ST_LOAD: begin
          ma <= 40'(signed'(coord));
          mb <= wsel;
          if (idx[1:0] == 2'd0) acc <= '0;
          cnt <= 5'd0;
          state <= ST_SUM;
        end
        ST_DIV3: begin
          r3 <= ge3 ? 2'(t3 - 3'd3) : t3[1:0];
          sh3 <= sh3 << 1;
          q3 <= q3_n;
          cnt <= cnt + 5'd1;
          if (cnt == bpf_pkg::DIV3_STEPS - 5'd1) begin
            cnt <= 5'd0;
            if (!idx[2]) begin
              px <= val3;
              idx <= 3'd4;
              state <= ST_LOAD;
            end else begin
              py <= val3;
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            pos_x <= px;
            pos_y <= py;
            heading_deg <= {hq, 4'd0} - 9'(hq);
            segment_index <= q[17:16];
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_lap_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> travelled < {lim_eff, 16'd0})
    else $error("distance not below lap limit");

  a_mod_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_MOD |-> rm < lim_eff)
    else $error("wrap remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> {1'b0, rem} < big_l)
    else $error("segment remainder out of range");

  a_seg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segment_index != 2'd3 && heading_deg <= 9'd345)
    else $error("segment or heading out of range");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [8:0]         hdg;
    logic [1:0]         seg;
  } pose_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [15:0] et;
    bit          typed;
    pose_t       want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = bpf_pkg::REG_POINT0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        elapsed_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic [8:0]         heading_deg;
  logic [1:0]         segment_index;

  bspline_path_follower uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .elapsed_time(elapsed_time),
    .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y),
    .heading_deg(heading_deg), .segment_index(segment_index)
  );

  // shadow of the block's registers and lap distance
  logic [31:0] pts [bpf_pkg::PT_NUM];
  logic [15:0] lap_lim;
  logic [9:0]  speed;
  logic [31:0] lap_dist;

  pose_t pose_q[$];
  row_t  plan[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_req = 0;
  longint unsigned cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic pose_t advance_pose(input logic [15:0] et);
    longint unsigned lim, lap, d, p, s, rem, u, u2, u3, m, m2, m3, hd;
    longint w[4];
    longint sx, sy;
    logic [31:0] pt;
    pose_t r;
    lim = lap_lim;
    if (lim == 0) lim = 1;
    lap = lim << 16;
    d = longint'(lap_dist) + longint'(et) * longint'(speed);
    if (d >= lap) d = d % lap;
    lap_dist = d[31:0];
    p = d * 3;
    s = p / lap;
    rem = p - s * lap;
    u = (rem << 16) / lap;
    u2 = (u * u) >> 16;
    u3 = (u2 * u) >> 16;
    m = 65536 - u;
    m2 = (m * m) >> 16;
    m3 = (m2 * m) >> 16;
    w[0] = m3;
    w[1] = 3 * longint'(u3) - 6 * longint'(u2) + 4 * 65536;
    w[2] = -3 * longint'(u3) + 3 * longint'(u2) + 3 * longint'(u) + 65536;
    w[3] = u3;
    sx = 0;
    sy = 0;
    for (int k = 0; k < 4; k++) begin
      pt = pts[(s + k) % bpf_pkg::PT_NUM];
      sx += w[k] * longint'(signed'(pt[15:0]));
      sy += w[k] * longint'(signed'(pt[31:16]));
    end
    sx = (sx * 16) / 393216;
    sy = (sy * 16) / 393216;
    hd = ((d * 24) / lap) * 15;
    r.x = sx[19:0];
    r.y = sy[19:0];
    r.hdg = hd[8:0];
    r.seg = s[1:0];
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bpf_pkg::REG_LIMIT) lap_lim = val[15:0];
    else if (idx == bpf_pkg::REG_SPEED) speed = val[9:0];
    else pts[idx] = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pose_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // returns with the word accepted, at that edge
  task automatic send_tick(input logic [15:0] et, output pose_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    elapsed_time <= et;
    do @(posedge clk); while (!in_ready);
    p = advance_pose(et);
    pose_q.push_back(p);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (2500) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    pose_t e;
    if (!rst && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d hdg=%0d seg=%0d", $time,
                 pos_x, pos_y, heading_deg, segment_index);
        mismatches++;
      end else begin
        e = pose_q.pop_front();
        if (pos_x !== e.x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, e.x, pos_x);
          mismatches++;
        end
        if (pos_y !== e.y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, e.y, pos_y);
          mismatches++;
        end
        if (heading_deg !== e.hdg) begin
          $display("%0t: heading_deg expected %0d actual %0d", $time, e.hdg, heading_deg);
          mismatches++;
        end
        if (segment_index !== e.seg) begin
          $display("%0t: segment_index expected %0d actual %0d", $time, e.seg,
                   segment_index);
          mismatches++;
        end
      end
    end
  end

  task automatic add_cfg(input logic [2:0] idx, input logic [31:0] val);
    row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: val, et: 16'd0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endtask

  task automatic add_tick(input logic [15:0] et, input bit typed, input pose_t want);
    row_t r;
    r = '{is_cfg: 1'b0, idx: bpf_pkg::REG_POINT0, data: 32'd0, et: et, typed: typed,
          want: want};
    plan.push_back(r);
  endtask

  function automatic logic [31:0] pick_point();
    case ($urandom_range(5))
      0: return 32'h7FFF_7FFF;
      1: return 32'h8000_8000;
      2: return 32'h7FFF_8000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    pose_t got, want;
    logic [15:0] lim_v, et;
    for (int i = 0; i < bpf_pkg::PT_NUM; i++) pts[i] = bpf_pkg::PT_RESET[i];
    lap_lim = bpf_pkg::LIMIT_RESET;
    speed = bpf_pkg::SPEED_RESET;
    lap_dist = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // start of lap after reset: segment 0 at u = 0
    add_tick(16'd0, 1, '{x: 20'sd2666, y: 20'sd1600, hdg: 9'd0, seg: 2'd0});
    add_tick(16'hFFFF, 0, '0);
    add_tick(16'h0001, 0, '0);
    add_tick(16'h8000, 0, '0);
    add_tick(16'h5555, 0, '0);
    add_tick(16'hAAAA, 0, '0);
    // zero speed holds the distance
    add_cfg(bpf_pkg::REG_SPEED, 32'd0);
    add_tick(16'hFFFF, 0, '0);
    // zero lap limit acts as one, long tick wraps many laps
    add_cfg(bpf_pkg::REG_SPEED, 32'hFFFF_FFFF);
    add_cfg(bpf_pkg::REG_LIMIT, 32'hFFFF_0000);
    add_tick(16'hFFFF, 0, '0);
    add_tick(16'h1234, 0, '0);
    add_cfg(bpf_pkg::REG_LIMIT, 32'd65535);
    for (int k = 0; k < bpf_pkg::PT_NUM; k++)
      add_cfg(bpf_pkg::REG_POINT0 + 3'(k), (k % 2) ? 32'h7FFF_7FFF : 32'h8000_8000);
    add_tick(16'hFFFF, 0, '0);
    add_tick(16'h7FFF, 0, '0);
    add_tick(16'hFFFF, 0, '0);
    add_tick(16'h0000, 0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].et, got);
        if (plan[i].typed && got !== plan[i].want) begin
          $display("%0t: row %0d expected %p predicted %p", $time, i, plan[i].want, got);
          mismatches++;
        end
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      in_valid <= 1'b0;
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int k = 0; k < bpf_pkg::PT_NUM; k++)
        write_reg(bpf_pkg::REG_POINT0 + 3'(k), pick_point());
      case (ph)
        0: lim_v = 16'd1;
        1: lim_v = 16'hFFFF;
        2: lim_v = 16'd0;
        3: lim_v = 16'd600;
        default: lim_v = 16'($urandom_range(2000, 1));
      endcase
      write_reg(bpf_pkg::REG_LIMIT, {16'($urandom_range(65535)), lim_v});
      write_reg(bpf_pkg::REG_SPEED,
                (ph == 5) ? 32'd1023 : ($urandom_range(31) << 10 | $urandom_range(1023)));
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 105; n++) begin
        case ($urandom_range(9))
          0: et = 16'h0000;
          1: et = 16'hFFFF;
          2: et = 16'($urandom_range(255));
          default: et = 16'($urandom);
        endcase
        send_tick(et, got);
      end
    end
    in_valid <= 1'b0;

    while (pose_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
